// ===== rtl/core/ili_pkg.sv =====
// package for the indexed list block: item structs, action and status codes,
// cell control struct and fsm states. no dependencies
`timescale 1ns / 1ps

package ili_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 16;

    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 11;
    localparam int ITEM_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 11;

    // wide enough for any index or count up to the largest supported capacity
    localparam int IDX_MAX_W  = 13;

    // cells per first-level group of the read gather
    localparam int GROUP_SIZE = 64;

    localparam logic [ACTION_W-1:0] ACT_GET      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_HEAD = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD_TAIL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ADD_AT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [POSITION_W-1:0] position;
        logic [ITEM_W-1:0]     item_value;
    } request_t;

    typedef struct packed {
        logic [ITEM_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] length;
    } result_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_READ,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   pos;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_GATHER,
        FSM_REPORT
    } fsm_state_t;

endpackage

// ===== rtl/core/ili_cell.sv =====
// one storage cell of the list row: holds one entry, shifts with its neighbors
// depends on ili_pkg
`timescale 1ns / 1ps

module ili_cell
    import ili_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [VALUE_BITS-1:0] ins_value,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic [VALUE_BITS-1:0] right_value,
    output logic [VALUE_BITS-1:0] value,
    output logic [VALUE_BITS-1:0] rd_value
);

    localparam logic [IDX_MAX_W-1:0] MY_INDEX = IDX_MAX_W'(INDEX);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [VALUE_BITS-1:0] rd_reg;
    logic [VALUE_BITS-1:0] rd_next;

    always_comb
    begin
        value_next = value_reg;
        rd_next    = '0;
        case (ctrl.op)
            CELL_READ:
            begin
                if (MY_INDEX == ctrl.pos)
                    rd_next = value_reg;
            end
            CELL_INSERT:
            begin
                // entries at or past the slot move one place right
                if (MY_INDEX > ctrl.pos)
                    value_next = left_value;
                else if (MY_INDEX == ctrl.pos)
                    value_next = ins_value;
            end
            CELL_DELETE:
            begin
                if (MY_INDEX >= ctrl.pos)
                    value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rd_reg    <= rd_next;
    end

    assign value    = value_reg;
    assign rd_value = rd_reg;

endmodule

// ===== rtl/core/ili_gather.sv =====
// two-stage read gather: registered or over groups of cells, then or over groups
// depends on ili_pkg
`timescale 1ns / 1ps

module ili_gather
    import ili_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic [VALUE_BITS-1:0] cell_rd [CAPACITY],
    output logic [VALUE_BITS-1:0] gathered
);

    localparam int NGROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [VALUE_BITS-1:0] slice     [NGROUPS][GROUP_SIZE];
    logic [VALUE_BITS-1:0] group_reg [NGROUPS];

    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_group
        logic [VALUE_BITS-1:0] group_next;

        for (genvar j = 0; j < GROUP_SIZE; j++)
        begin : g_tap
            if (g * GROUP_SIZE + j < CAPACITY)
            begin : g_live
                assign slice[g][j] = cell_rd[g * GROUP_SIZE + j];
            end
            else
            begin : g_pad
                assign slice[g][j] = '0;
            end
        end

        always_comb
        begin
            group_next = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
                group_next = group_next | slice[g][j];
        end

        always_ff @(posedge clk)
        begin
            group_reg[g] <= group_next;
        end
    end

    always_comb
    begin
        gathered = '0;
        for (int g = 0; g < NGROUPS; g++)
            gathered = gathered | group_reg[g];
    end

endmodule

// ===== rtl/core/indexed_list_insert_delete.sv =====
// indexed list store: an item runs through exec (cell row update and cell
// read register), gather (group register of the read gather) and report
// (result register). busy is high from acceptance until the done cycle.
// done lasts one cycle, result keeps its value after it; the receiver cannot stall.
// reset clears the length to 0; entries are not cleared and need no sweep.
// depends on ili_pkg, ili_cell, ili_gather
`timescale 1ns / 1ps

module indexed_list_insert_delete
    import ili_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    request_t   req_reg;
    request_t   req_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                rd_ok_reg;
    logic                rd_ok_next;
    logic                done_reg;
    logic                done_next;
    result_t             result_reg;
    result_t             result_next;

    cell_ctrl_t            ctrl;
    logic [VALUE_BITS-1:0] ins_value;
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [VALUE_BITS-1:0] cell_rd    [CAPACITY];
    logic [VALUE_BITS-1:0] gathered;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             in_range;
    logic             full;

    assign pos_ext   = CMP_W'(req_reg.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign in_range  = pos_ext < cnt_ext;
    assign full      = count_reg == CNT_FULL;
    assign ins_value = VALUE_BITS'(req_reg.item_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ctrl.op     = CELL_HOLD;
        ctrl.pos    = IDX_MAX_W'(pos_ext);

        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                status_next = STAT_INVALID;
                rd_ok_next  = 1'b0;
                case (req_reg.action)
                    ACT_GET:
                    begin
                        if (in_range)
                        begin
                            ctrl.op     = CELL_READ;
                            status_next = STAT_DONE;
                            rd_ok_next  = 1'b1;
                        end
                    end
                    ACT_ADD_HEAD:
                    begin
                        ctrl.pos = '0;
                        if (full)
                            status_next = STAT_FULL;
                        else
                        begin
                            ctrl.op     = CELL_INSERT;
                            status_next = STAT_DONE;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    ACT_ADD_TAIL:
                    begin
                        ctrl.pos = IDX_MAX_W'(count_reg);
                        if (full)
                            status_next = STAT_FULL;
                        else
                        begin
                            ctrl.op     = CELL_INSERT;
                            status_next = STAT_DONE;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    ACT_ADD_AT:
                    begin
                        // index test comes before the full test
                        if (pos_ext <= cnt_ext)
                        begin
                            if (full)
                                status_next = STAT_FULL;
                            else
                            begin
                                ctrl.op     = CELL_INSERT;
                                status_next = STAT_DONE;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (in_range)
                        begin
                            ctrl.op     = CELL_DELETE;
                            status_next = STAT_DONE;
                            count_next  = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_INVALID;
                    end
                endcase
                state_next = FSM_GATHER;
            end
            FSM_GATHER:
            begin
                state_next = FSM_REPORT;
            end
            FSM_REPORT:
            begin
                result_next.read_value = rd_ok_reg ? ITEM_W'(gathered) : '0;
                result_next.status     = status_reg;
                result_next.length     = LENGTH_W'(count_reg);
                done_next              = 1'b1;
                state_next             = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_value;
        logic [VALUE_BITS-1:0] right_value;

        // end cells see themselves where they have no neighbor
        if (i == 0)
        begin : g_first
            assign left_value = cell_value[i];
        end
        else
        begin : g_left
            assign left_value = cell_value[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_right
            assign right_value = cell_value[i + 1];
        end

        ili_cell #(
            .INDEX      (i),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .ins_value   (ins_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .rd_value    (cell_rd[i])
        );
    end

    ili_gather #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_gather (
        .clk      (clk),
        .cell_rd  (cell_rd),
        .gathered (gathered)
    );

    assign busy   = state_reg != FSM_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
